@@ hw/rtl/rpk_pkg.sv @@
// shared types, constants and helpers for the bitmap row repacker
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps
`default_nettype none

package rpk_pkg;

  // size limits
  localparam int MaxWidth  = 4096;
  localparam int MaxHeight = 4096;

  // field and counter widths
  localparam int CfgW     = 13;                          // size registers
  localparam int ByteW    = 8;
  localparam int ColW     = $clog2(MaxWidth / ByteW);    // byte position in a row
  localparam int UsedW    = $clog2(MaxWidth / ByteW + 1); // bytes used per row
  localparam int RowW     = $clog2(MaxHeight);           // row index
  localparam int CfgIdxW  = 3;

  // register indexes of the write port
  typedef enum logic [CfgIdxW-1:0] {
    CFG_IMAGE_WIDTH  = 3'd0,
    CFG_SOURCE_WIDTH = 3'd1,
    CFG_IMAGE_HEIGHT = 3'd2,
    CFG_BIT_REVERSE  = 3'd3,
    CFG_BYTE_SWAP    = 3'd4
  } cfg_idx_e;

  // derived geometry and mode bits handed to the core
  typedef struct packed {
    logic [UsedW-1:0] used;        // bytes used per row, 1..MaxWidth/8
    logic [ColW-1:0]  stride_m1;   // source row stride minus one
    logic [RowW-1:0]  height_m1;   // rows per image minus one
    logic             bit_reverse;
    logic             byte_swap;
  } cfg_t;

  function automatic logic [ByteW-1:0] reverse8(input logic [ByteW-1:0] b);
    logic [ByteW-1:0] r;
    for (int i = 0; i < ByteW; i++) begin
      r[ByteW-1-i] = b[i];
    end
    return r;
  endfunction

  // clamp a size register into 1..hi
  function automatic logic [CfgW-1:0] clamp_size(input logic [CfgW-1:0] v,
                                                 input logic [CfgW-1:0] hi);
    logic [CfgW-1:0] r;
    if (v == '0) begin
      r = CfgW'(1);
    end else if (v > hi) begin
      r = hi;
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

@@ hw/rtl/rpk_cfg.sv @@
// configuration registers and derived row geometry
// depends on rpk_pkg
`timescale 1ns / 1ps
`default_nettype none

module rpk_cfg (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        cfg_we_i,
  input  wire logic [rpk_pkg::CfgIdxW-1:0] cfg_index_i,
  input  wire logic [rpk_pkg::CfgW-1:0]    cfg_wdata_i,
  output rpk_pkg::cfg_t                    cfg_o
);
  import rpk_pkg::*;

  localparam logic [CfgW-1:0] WidthMax  = CfgW'(MaxWidth);
  localparam logic [CfgW-1:0] HeightMax = CfgW'(MaxHeight);

  logic [CfgW-1:0] width_q, source_q, height_q;
  logic            rev_q, swap_q;

  logic [CfgW-1:0] w_c, s_c, s_eff, h_c;
  logic [CfgW-1:0] used_full, stride_full;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= CfgW'(8);
      source_q <= CfgW'(8);
      height_q <= CfgW'(1);
      rev_q    <= 1'b0;
      swap_q   <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_IMAGE_WIDTH:  width_q  <= cfg_wdata_i;
        CFG_SOURCE_WIDTH: source_q <= cfg_wdata_i;
        CFG_IMAGE_HEIGHT: height_q <= cfg_wdata_i;
        CFG_BIT_REVERSE:  rev_q    <= cfg_wdata_i[0];
        CFG_BYTE_SWAP:    swap_q   <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    w_c   = clamp_size(width_q, WidthMax);
    s_c   = clamp_size(source_q, WidthMax);
    h_c   = clamp_size(height_q, HeightMax);
    // a narrow source row is taken as wide as the image
    s_eff = (s_c < w_c) ? w_c : s_c;
    used_full   = (w_c + CfgW'(7)) >> 3;
    stride_full = ((s_eff + CfgW'(7)) >> 3) - CfgW'(1);

    cfg_o.used        = used_full[UsedW-1:0];
    cfg_o.stride_m1   = stride_full[ColW-1:0];
    cfg_o.height_m1   = RowW'(h_c - CfgW'(1));
    cfg_o.bit_reverse = rev_q;
    cfg_o.byte_swap   = swap_q;
  end

endmodule

`default_nettype wire

@@ hw/rtl/rpk_core.sv @@
// input register, byte pairing logic and result register
// depends on rpk_pkg
`timescale 1ns / 1ps
`default_nettype none

module rpk_core (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  rpk_pkg::cfg_t                  cfg_i,
  input  wire logic                      in_valid_i,
  output logic                           in_stall_o,
  input  wire logic [rpk_pkg::ByteW-1:0] source_byte_i,
  output logic                           out_valid_o,
  input  wire logic                      out_stall_i,
  output logic [rpk_pkg::ByteW-1:0]      low_address_byte_o,
  output logic [rpk_pkg::ByteW-1:0]      high_address_byte_o,
  output logic                           last_word_o
);
  import rpk_pkg::*;

  // input register
  logic             in_valid_q, in_valid_d;
  logic [ByteW-1:0] in_byte_q;

  // row state
  logic [ColW-1:0]  col_q, col_d;
  logic [RowW-1:0]  row_q, row_d;
  logic [ByteW-1:0] held_q, held_d;
  logic             holding_q, holding_d;

  // result register
  logic             out_valid_q, out_valid_d;
  logic [ByteW-1:0] lo_q, lo_d, hi_q, hi_d;
  logic             last_q, last_d;

  logic             advance, accept;
  logic [ByteW-1:0] b, first, second;
  logic             in_used, end_used, end_row, last_row, emit;

  assign advance    = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !advance;
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    b        = cfg_i.bit_reverse ? reverse8(in_byte_q) : in_byte_q;
    in_used  = {1'b0, col_q} < cfg_i.used;
    end_used = {1'b0, col_q} == (cfg_i.used - UsedW'(1));
    end_row  = col_q >= cfg_i.stride_m1;
    last_row = row_q >= cfg_i.height_m1;
    emit     = in_used && (holding_q || end_used);
    first    = holding_q ? held_q : b;
    second   = holding_q ? b : '0;

    in_valid_d = accept ? 1'b1 : (advance ? 1'b0 : in_valid_q);

    col_d     = col_q;
    row_d     = row_q;
    held_d    = held_q;
    holding_d = holding_q;
    if (advance) begin
      if (in_used) begin
        if (holding_q) begin
          holding_d = 1'b0;
        end else if (!end_used) begin
          held_d    = b;
          holding_d = 1'b1;
        end
      end
      if (end_row) begin
        col_d     = '0;
        holding_d = 1'b0;      // a byte still held at row end is dropped
        row_d     = last_row ? '0 : row_q + RowW'(1);
      end else begin
        col_d = col_q + ColW'(1);
      end
    end

    lo_d   = lo_q;
    hi_d   = hi_q;
    last_d = last_q;
    if (advance && emit) begin
      out_valid_d = 1'b1;
      lo_d        = cfg_i.byte_swap ? second : first;
      hi_d        = cfg_i.byte_swap ? first : second;
      last_d      = end_used && last_row;
    end else begin
      out_valid_d = out_valid_q && out_stall_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      col_q       <= '0;
      row_q       <= '0;
      held_q      <= '0;
      holding_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      col_q       <= col_d;
      row_q       <= row_d;
      held_q      <= held_d;
      holding_q   <= holding_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_byte_q <= source_byte_i;
    end
    lo_q   <= lo_d;
    hi_q   <= hi_d;
    last_q <= last_d;
  end

  assign out_valid_o         = out_valid_q;
  assign low_address_byte_o  = lo_q;
  assign high_address_byte_o = hi_q;
  assign last_word_o         = last_q;

endmodule

`default_nettype wire

@@ hw/rtl/bitmap_row_repacker.sv @@
// top level of the bitmap row repacker: config registers and repacking core
// depends on rpk_pkg, rpk_cfg and rpk_core
`timescale 1ns / 1ps
`default_nettype none

// Repacks a 1-bit-per-pixel bitmap, fed one source byte per beat in row-major
// order, into 16-bit words given as an even-address and an odd-address byte.
// Each source row is ceil(source_width/8) bytes; only the first
// ceil(image_width/8) bytes are used and the rest give no word. Used bytes are
// optionally bit-reversed, paired into words, and optionally byte-swapped; an
// odd row ends in a word padded with a zero byte (first position under swap).
// The final word of the image carries last_word. Sizes are clamped to 1..4096
// and a source narrower than the image is taken as the image width.
// Rate: one source byte per clock cycle, sustained while the word side takes
// every beat. A byte waits in the input register; its word is then written
// to the result register, from which it can leave. A held-off word side
// stalls the input once both the input and the result register are full.
// Registers may only be written while no beat is in flight; they act on the
// next byte taken.

module bitmap_row_repacker (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  // configuration write port
  input  wire logic                        cfg_we_i,
  input  wire logic [rpk_pkg::CfgIdxW-1:0] cfg_index_i,
  input  wire logic [rpk_pkg::CfgW-1:0]    cfg_wdata_i,
  // source byte channel
  input  wire logic                        in_valid_i,
  output logic                             in_stall_o,
  input  wire logic [rpk_pkg::ByteW-1:0]   source_byte_i,
  // word channel
  output logic                             out_valid_o,
  input  wire logic                        out_stall_i,
  output logic [rpk_pkg::ByteW-1:0]        low_address_byte_o,
  output logic [rpk_pkg::ByteW-1:0]        high_address_byte_o,
  output logic                             last_word_o
);
  import rpk_pkg::*;

  // clamped geometry and mode bits
  cfg_t cfg;

  rpk_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  // byte pairing between the input and result registers
  rpk_core u_core (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cfg_i               (cfg),
    .in_valid_i          (in_valid_i),
    .in_stall_o          (in_stall_o),
    .source_byte_i       (source_byte_i),
    .out_valid_o         (out_valid_o),
    .out_stall_i         (out_stall_i),
    .low_address_byte_o  (low_address_byte_o),
    .high_address_byte_o (high_address_byte_o),
    .last_word_o         (last_word_o)
  );

endmodule

`default_nettype wire

@@ test/rpk_word_checker.sv @@
// word checker for the bitmap row repacker: predicts every output word
// from the source beats and register writes it sees; needs rpk_pkg only
`timescale 1ns / 1ps

module rpk_word_checker (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [rpk_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [rpk_pkg::CfgW-1:0]    cfg_wdata_i,
  input  logic                        in_valid_i,
  input  logic                        in_stall_i,
  input  logic [rpk_pkg::ByteW-1:0]   source_byte_i,
  input  logic                        out_valid_i,
  input  logic                        out_stall_i,
  input  logic [rpk_pkg::ByteW-1:0]   low_address_byte_i,
  input  logic [rpk_pkg::ByteW-1:0]   high_address_byte_i,
  input  logic                        last_word_i,
  output int                          pending_words_o,
  output int                          mismatch_count_o
);
  import rpk_pkg::*;

  typedef struct packed {
    logic [ByteW-1:0] low_byte;
    logic [ByteW-1:0] high_byte;
    logic             last;
  } word_t;

  word_t       pending_words[$];
  word_t       oldest_word;

  // shadow registers
  int unsigned width_reg;
  int unsigned source_reg;
  int unsigned height_reg;
  logic        mirror_on;
  logic        swap_on;

  // repacking state
  int unsigned      byte_pos;
  int unsigned      row_pos;
  logic [ByteW-1:0] held_byte;
  logic             held_valid;

  int mismatches;

  assign mismatch_count_o = mismatches;

  function automatic int unsigned clamp_dim(input int unsigned v, input int unsigned hi);
    int unsigned r;
    r = v;
    if (r < 1) r = 1;
    if (r > hi) r = hi;
    return r;
  endfunction

  task automatic report_mismatch(input string what);
    $display("%0t ns: word mismatch: %s", $realtime, what);
    mismatches++;
  endtask

  task automatic repack_byte(input logic [ByteW-1:0] raw);
    int unsigned      w;
    int unsigned      s;
    int unsigned      h;
    int unsigned      used;
    int unsigned      stride;
    logic [ByteW-1:0] b;
    logic [ByteW-1:0] first;
    logic [ByteW-1:0] second;
    logic             emit;
    logic             row_tail;
    word_t            word;

    w = clamp_dim(width_reg, MaxWidth);
    s = clamp_dim(source_reg, MaxWidth);
    h = clamp_dim(height_reg, MaxHeight);
    if (s < w) s = w;
    used   = (w + 7) / 8;
    stride = (s + 7) / 8;

    b = raw;
    if (mirror_on) begin
      for (int i = 0; i < ByteW; i++) b[ByteW-1-i] = raw[i];
    end

    if (byte_pos < used) begin
      row_tail = (byte_pos == used - 1);
      emit     = 1'b0;
      first    = '0;
      second   = '0;
      if (held_valid) begin
        first      = held_byte;
        second     = b;
        held_valid = 1'b0;
        emit       = 1'b1;
      end else if (row_tail) begin
        first = b;
        emit  = 1'b1;
      end else begin
        held_byte  = b;
        held_valid = 1'b1;
      end
      if (emit) begin
        word.low_byte  = swap_on ? second : first;
        word.high_byte = swap_on ? first : second;
        word.last      = row_tail && (row_pos >= h - 1);
        pending_words.push_back(word);
      end
    end

    // end of source row, possibly reached early after a register change
    if (byte_pos >= stride - 1) begin
      byte_pos   = 0;
      held_valid = 1'b0;
      row_pos    = (row_pos >= h - 1) ? 0 : row_pos + 1;
    end else begin
      byte_pos++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_reg       = 8;
      source_reg      = 8;
      height_reg      = 1;
      mirror_on       = 1'b0;
      swap_on         = 1'b0;
      byte_pos        = 0;
      row_pos         = 0;
      held_byte       = '0;
      held_valid      = 1'b0;
      mismatches      = 0;
      pending_words.delete();
      pending_words_o <= 0;
    end else begin
      // words leave first: a word never stems from a beat of the same edge
      if (out_valid_i && !out_stall_i) begin
        if (pending_words.size() == 0) begin
          report_mismatch($sformatf("unexpected word %02h %02h last %b",
                                    low_address_byte_i, high_address_byte_i, last_word_i));
        end else begin
          oldest_word = pending_words.pop_front();
          if (low_address_byte_i !== oldest_word.low_byte)
            report_mismatch($sformatf("low_address_byte %02h, predicted %02h",
                                      low_address_byte_i, oldest_word.low_byte));
          if (high_address_byte_i !== oldest_word.high_byte)
            report_mismatch($sformatf("high_address_byte %02h, predicted %02h",
                                      high_address_byte_i, oldest_word.high_byte));
          if (last_word_i !== oldest_word.last)
            report_mismatch($sformatf("last_word %b, predicted %b",
                                      last_word_i, oldest_word.last));
        end
      end
      if (in_valid_i && !in_stall_i) begin
        repack_byte(source_byte_i);
      end
      // a write acts on the beats after this edge
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_index_i))
          CFG_IMAGE_WIDTH:  width_reg  = 32'(cfg_wdata_i);
          CFG_SOURCE_WIDTH: source_reg = 32'(cfg_wdata_i);
          CFG_IMAGE_HEIGHT: height_reg = 32'(cfg_wdata_i);
          CFG_BIT_REVERSE:  mirror_on  = cfg_wdata_i[0];
          CFG_BYTE_SWAP:    swap_on    = cfg_wdata_i[0];
          default: ;
        endcase
      end
      pending_words_o <= pending_words.size();
    end
  end

endmodule

@@ test/tb_bitmap_row_repacker.sv @@
// testbench top for the bitmap row repacker: clock, reset, source beats,
// word-side stalls and register settings; words are checked by rpk_word_checker
`timescale 1ns / 1ps

module tb_bitmap_row_repacker;
  import rpk_pkg::*;

  localparam int LimitCycles = 200000;
  localparam int ItemTarget  = 700;   // source beats in the random part
  localparam int SettleWait  = 4;     // two-stage pipeline plus margin
  localparam int MaxCfg      = (1 << CfgW) - 1;

  logic             clk;
  logic             rst_n;
  logic             cfg_we;
  cfg_idx_e         cfg_index;
  logic [CfgW-1:0]  cfg_wdata;
  logic             in_valid;
  logic             in_stall;
  logic [ByteW-1:0] source_byte;
  logic             out_valid;
  logic             out_stall;
  logic [ByteW-1:0] low_byte;
  logic [ByteW-1:0] high_byte;
  logic             last_word;

  int          pending_words;
  int          mismatch_count;
  int unsigned cycle_count = 0;
  bit          gaps_on;        // random idling on both sides
  int          hold_request;   // long word-side hold, picked up by the sink

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  bitmap_row_repacker u_dut (
    .clk_i               (clk),
    .rst_ni              (rst_n),
    .cfg_we_i            (cfg_we),
    .cfg_index_i         (cfg_index),
    .cfg_wdata_i         (cfg_wdata),
    .in_valid_i          (in_valid),
    .in_stall_o          (in_stall),
    .source_byte_i       (source_byte),
    .out_valid_o         (out_valid),
    .out_stall_i         (out_stall),
    .low_address_byte_o  (low_byte),
    .high_address_byte_o (high_byte),
    .last_word_o         (last_word)
  );

  rpk_word_checker u_checker (
    .clk_i               (clk),
    .rst_ni              (rst_n),
    .cfg_we_i            (cfg_we),
    .cfg_index_i         (cfg_index),
    .cfg_wdata_i         (cfg_wdata),
    .in_valid_i          (in_valid),
    .in_stall_i          (in_stall),
    .source_byte_i       (source_byte),
    .out_valid_i         (out_valid),
    .out_stall_i         (out_stall),
    .low_address_byte_i  (low_byte),
    .high_address_byte_i (high_byte),
    .last_word_i         (last_word),
    .pending_words_o     (pending_words),
    .mismatch_count_o    (mismatch_count)
  );

  // watchdog: a hung handshake ends the run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LimitCycles) begin
      $display("FAILURE");
      $finish;
    end
  end

  // word sink: random stalls, or a long hold when the stimulus asks for one
  initial begin
    int hold_left;
    int hold_taken;
    out_stall  = 1'b0;
    hold_left  = 0;
    hold_taken = 0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_request != hold_taken) begin
        hold_left  = hold_request;
        hold_taken = hold_request;
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= gaps_on && ($urandom_range(0, 99) < 19);
      end
    end
  end

  // all tasks start and end at a falling edge

  // one source beat, with random idle cycles in front of it
  task automatic offer_byte(input logic [ByteW-1:0] b);
    while (gaps_on && ($urandom_range(0, 99) < 19)) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid    <= 1'b1;
    source_byte <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  // stop sending and wait until every predicted word is out; a byte with
  // no word may still sit in the pipeline, hence the extra settle cycles
  task automatic drain_words();
    in_valid <= 1'b0;
    while (pending_words != 0) @(negedge clk);
    repeat (SettleWait) @(negedge clk);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [CfgW-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(negedge clk);
  endtask

  // new image setting, written only once the block is idle; the row and
  // byte counters carry over, so this also lands mid-image
  task automatic set_image(input logic [CfgW-1:0] w, input logic [CfgW-1:0] s,
                           input logic [CfgW-1:0] h, input logic [CfgW-1:0] rev,
                           input logic [CfgW-1:0] swap);
    drain_words();
    write_reg(CFG_IMAGE_WIDTH, w);
    write_reg(CFG_SOURCE_WIDTH, s);
    write_reg(CFG_IMAGE_HEIGHT, h);
    write_reg(CFG_BIT_REVERSE, rev);
    write_reg(CFG_BYTE_SWAP, swap);
    cfg_we <= 1'b0;
  endtask

  // sizes at and beyond the clamp limits
  function automatic logic [CfgW-1:0] edge_size();
    logic [CfgW-1:0] v;
    case ($urandom_range(0, 5))
      0:       v = '0;
      1:       v = CfgW'(1);
      2:       v = CfgW'(MaxWidth - 1);
      3:       v = CfgW'(MaxWidth);
      4:       v = CfgW'(MaxWidth + 1);
      default: v = CfgW'(MaxCfg);
    endcase
    return v;
  endfunction

  function automatic logic [CfgW-1:0] pick_width();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 8) return edge_size();
    if (r < 75) return CfgW'($urandom_range(1, 48));
    return CfgW'($urandom_range(49, 300));
  endfunction

  // equal, narrower (taken as equal) or wider source rows
  function automatic logic [CfgW-1:0] pick_source(input logic [CfgW-1:0] w);
    int unsigned r;
    int unsigned sum;
    r = $urandom_range(0, 99);
    if (r < 35) return w;
    if (r < 50) return CfgW'($urandom_range(0, w));
    if (r < 92) begin
      sum = w + $urandom_range(1, 40);
      return (sum > MaxCfg) ? CfgW'(MaxCfg) : CfgW'(sum);
    end
    return edge_size();
  endfunction

  function automatic logic [CfgW-1:0] pick_height();
    if ($urandom_range(0, 99) < 6) return edge_size();
    return CfgW'($urandom_range(0, 5));
  endfunction

  // flag registers only look at bit 0; the other bits get noise
  function automatic logic [CfgW-1:0] pick_flag();
    return CfgW'($urandom_range(0, MaxCfg));
  endfunction

  initial begin
    int phase;
    int beats;
    int sent;

    cfg_we       = 1'b0;
    cfg_index    = CFG_IMAGE_WIDTH;
    cfg_wdata    = '0;
    in_valid     = 1'b0;
    source_byte  = '0;
    gaps_on      = 1'b1;
    hold_request = 0;
    rst_n        = 1'b0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset setting: one byte per row, every byte a padded last word
    offer_byte(8'h00);
    offer_byte(8'hFF);
    offer_byte(8'h01);
    offer_byte(8'h80);
    offer_byte(8'hA5);

    // odd row of three used bytes, two slack bytes, mirror and swap, two rows
    set_image(CfgW'(24), CfgW'(40), CfgW'(2), CfgW'(1), CfgW'(1));
    offer_byte(8'h01);
    offer_byte(8'h02);
    offer_byte(8'h0F);
    offer_byte(8'hFF);
    offer_byte(8'hEE);
    offer_byte(8'hC3);
    offer_byte(8'h5A);
    offer_byte(8'h80);
    offer_byte(8'h11);
    offer_byte(8'h22);

    // narrow source taken as image width, zero height taken as one
    set_image(CfgW'(16), CfgW'(1), '0, '0, '0);
    offer_byte(8'h12);
    offer_byte(8'h34);
    offer_byte(8'hF0);
    offer_byte(8'h0F);

    // a held byte, then a shrink of the row: the held byte is dropped
    set_image(CfgW'(32), CfgW'(32), CfgW'(3), '0, CfgW'(1));
    offer_byte(8'h7E);
    set_image(CfgW'(8), CfgW'(8), CfgW'(1), CfgW'(1), '0);
    offer_byte(8'h99);
    offer_byte(8'h3C);

    // random settings, each followed by a burst of random bytes
    phase = 0;
    sent  = 0;
    while (sent < ItemTarget) begin
      beats = $urandom_range(8, 60);
      case (phase)
        0: begin
          // widest rows, tallest image
          set_image(CfgW'(MaxCfg), '0, CfgW'(MaxCfg), pick_flag(), pick_flag());
          beats = 40;
        end
        1: begin
          // single used byte in the longest source row, mostly slack
          set_image('0, CfgW'(MaxCfg), CfgW'(MaxHeight), pick_flag(), pick_flag());
          beats = 20;
        end
        3: begin
          // sink holds off while beats keep coming: the block fills and stalls
          set_image(CfgW'(64), CfgW'(64), pick_height(), pick_flag(), pick_flag());
          hold_request = 300;
          beats        = 80;
        end
        5: begin
          // full rate on both sides
          set_image(CfgW'(40), CfgW'(48), pick_height(), pick_flag(), pick_flag());
          gaps_on = 1'b0;
          beats   = 150;
        end
        default: begin
          logic [CfgW-1:0] w;
          w = pick_width();
          set_image(w, pick_source(w), pick_height(), pick_flag(), pick_flag());
        end
      endcase
      repeat (beats) offer_byte(ByteW'($urandom_range(0, 255)));
      sent    = sent + beats;
      gaps_on = 1'b1;
      phase++;
    end

    drain_words();
    repeat (SettleWait) @(negedge clk);
    if (mismatch_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
hw/rtl/rpk_pkg.sv
hw/rtl/rpk_cfg.sv
hw/rtl/rpk_core.sv
hw/rtl/bitmap_row_repacker.sv
test/rpk_word_checker.sv
test/tb_bitmap_row_repacker.sv
